// ===== sv/fpsl_pkg.sv =====
package fpsl_pkg;

    // Bits shifted out per configuration byte, one DCLK pulse each.
    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);

    // Register defaults after reset.
    localparam logic [7:0]  MAX_ATTEMPTS_RST = 8'd3;
    localparam logic [15:0] SYNC_TIMEOUT_RST = 16'd1000;
    localparam logic [15:0] RESET_HOLD_RST   = 16'd1000;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_ATTEMPTS = 2'd0,
        CFG_SYNC_TIMEOUT = 2'd1,
        CFG_RESET_HOLD   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_DATA  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HOLD   = 3'd1,
        PH_SYNC   = 3'd2,
        PH_LOAD   = 3'd3,
        PH_DONE   = 3'd4,
        PH_OK     = 3'd5,
        PH_FAILED = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_HOLD   = 3'd1,
        ST_SYNC   = 3'd2,
        ST_LOAD   = 3'd3,
        ST_DONE   = 3'd4,
        ST_OK     = 3'd5,
        ST_RETRY  = 3'd6,
        ST_FAILED = 3'd7
    } t_status;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
        logic       last_byte;
        logic       nstatus_pin;
        logic       cdone_pin;
    } t_in_item;

    typedef struct packed {
        logic       nconfig_drive;
        logic       data0_drive;
        logic       dclk_pulse;
        logic [2:0] status;
        logic [7:0] attempt_number;
        logic       last_of_run;
    } t_out_item;

    // One classified item, as the front hands it to the back.
    typedef struct packed {
        logic       multi;        // data byte in loading: eight pulses
        logic [7:0] data_byte;
        logic [7:0] pre_attempt;  // attempt shown on the first seven pulses
        logic       fin_nconfig;
        t_status    fin_status;
        logic [7:0] fin_attempt;
    } t_job;

endpackage

// ===== sv/fpsl_in_if.sv =====
interface fpsl_in_if
    import fpsl_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/fpsl_out_if.sv =====
interface fpsl_out_if
    import fpsl_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/fpsl_front.sv =====
module fpsl_front
    import fpsl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    fpsl_in_if.sink               i_in,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output t_job                  o_q_job
);

    logic [7:0]  r_max_attempts;
    logic [15:0] r_sync_timeout;
    logic [15:0] r_reset_hold;

    t_phase      r_phase, n_phase;
    logic [15:0] r_tick, n_tick;
    logic [7:0]  r_attempt, n_attempt;
    logic        n_retry;

    logic        load_byte;
    logic        fail;
    logic [15:0] tick_sat;

    assign i_in.ready = !i_q_full;
    assign o_q_push   = i_in.valid && !i_q_full;
    assign load_byte  = (i_in.data.command == CMD_DATA) && (r_phase == PH_LOAD);
    assign tick_sat   = (r_tick != 16'hFFFF) ? r_tick + 16'd1 : r_tick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_attempts <= MAX_ATTEMPTS_RST;
            r_sync_timeout <= SYNC_TIMEOUT_RST;
            r_reset_hold   <= RESET_HOLD_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MAX_ATTEMPTS: r_max_attempts <= i_cfg_data[7:0];
                CFG_SYNC_TIMEOUT: r_sync_timeout <= i_cfg_data;
                CFG_RESET_HOLD:   r_reset_hold   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state of the programming sequence.
    always_comb begin
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_attempt = r_attempt;
        n_retry   = 1'b0;
        fail      = 1'b0;
        unique case (t_cmd'(i_in.data.command))
            CMD_START: begin
                n_tick = '0;
                if (r_max_attempts == 8'd0) begin
                    n_attempt = '0;
                    n_phase   = PH_FAILED;
                end else begin
                    n_attempt = 8'd1;
                    n_phase   = PH_HOLD;
                end
            end
            CMD_TICK: begin
                unique case (r_phase)
                    PH_HOLD: begin
                        n_tick = tick_sat;
                        if (tick_sat >= r_reset_hold) begin
                            if (r_sync_timeout == 16'd0) begin
                                fail = 1'b1;
                            end else if (i_in.data.nstatus_pin) begin
                                n_phase = PH_LOAD;
                                n_tick  = '0;
                            end else begin
                                n_phase = PH_SYNC;
                                n_tick  = 16'd1;
                            end
                        end
                    end
                    PH_SYNC: begin
                        if (r_tick >= r_sync_timeout) begin
                            fail = 1'b1;
                        end else if (i_in.data.nstatus_pin) begin
                            n_phase = PH_LOAD;
                            n_tick  = '0;
                        end else begin
                            n_tick = r_tick + 16'd1;
                        end
                    end
                    PH_DONE: begin
                        n_tick = tick_sat;
                        if (i_in.data.cdone_pin) begin
                            n_phase = PH_OK;
                            n_tick  = '0;
                        end else if (tick_sat >= r_sync_timeout) begin
                            fail = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            CMD_DATA: begin
                if (load_byte) begin
                    if (!i_in.data.nstatus_pin) begin
                        fail = 1'b1;
                    end else if (i_in.data.last_byte) begin
                        n_tick = '0;
                        if (i_in.data.cdone_pin) begin
                            n_phase = PH_OK;
                        end else if (r_sync_timeout == 16'd0) begin
                            fail = 1'b1;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                end
            end
            default: ;
        endcase
        if (fail) begin
            n_tick = '0;
            if (r_attempt < r_max_attempts) begin
                n_attempt = r_attempt + 8'd1;
                n_phase   = PH_HOLD;
                n_retry   = 1'b1;
            end else begin
                n_phase = PH_FAILED;
            end
        end
    end

    // Job record handed to the back.
    always_comb begin
        o_q_job.multi       = load_byte;
        o_q_job.data_byte   = i_in.data.data_byte;
        o_q_job.pre_attempt = r_attempt;
        o_q_job.fin_nconfig = (n_phase != PH_HOLD);
        o_q_job.fin_status  = n_retry ? ST_RETRY : t_status'(3'(n_phase));
        o_q_job.fin_attempt = n_attempt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_tick    <= '0;
            r_attempt <= '0;
        end else if (o_q_push) begin
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_attempt <= n_attempt;
        end
    end

endmodule

// ===== sv/fpsl_queue.sv =====
module fpsl_queue
    import fpsl_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not grow on push");

endmodule

// ===== sv/fpsl_back.sv =====
module fpsl_back
    import fpsl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_job        i_q_job,
    output logic        o_q_pop,
    fpsl_out_if.source  o_out
);

    logic                 r_busy;
    t_job                 r_job;
    logic [BIT_IDX_W-1:0] r_idx;
    logic                 last;
    logic                 out_xfer;

    assign last     = !r_job.multi || (r_idx == BIT_IDX_W'(BITS_PER_BYTE - 1));
    assign out_xfer = o_out.valid && o_out.ready;
    assign o_q_pop  = i_q_valid && (!r_busy || (out_xfer && last));

    assign o_out.valid = r_busy;

    always_comb begin
        o_out.data.last_of_run = last;
        o_out.data.dclk_pulse  = r_job.multi;
        o_out.data.data0_drive = r_job.multi && r_job.data_byte[r_idx];
        if (last) begin
            o_out.data.nconfig_drive  = r_job.fin_nconfig;
            o_out.data.status         = r_job.fin_status;
            o_out.data.attempt_number = r_job.fin_attempt;
        end else begin
            o_out.data.nconfig_drive  = 1'b1;
            o_out.data.status         = ST_LOAD;
            o_out.data.attempt_number = r_job.pre_attempt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_q_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_q_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (out_xfer) begin
            if (last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && !last) |=> o_out.valid)
        else $error("pulse run broken off before its final bit");

    a_single_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_job.multi) |-> (r_idx == '0))
        else $error("bit index moved on a single-result item");

endmodule

// ===== sv/fpga_passive_serial_loader.sv =====
// Passive serial configuration loader.
// Input channel i_in carries commands: start, one 50 us tick, or a data
// byte with its last-byte flag, each with the sampled nSTATUS and done-line
// levels. Output channel o_out carries one result per DCLK pulse, or one
// result for every other command; last_of_run marks the final result of a
// command. Registers max_attempts, sync_timeout_ticks and reset_hold_ticks
// are written through i_cfg_we, i_cfg_idx and i_cfg_data; the user must
// write them only while idle, and the block itself does not enforce this.
// The front accepts one command per cycle as long as the job queue has room
// and updates the sequence state at once; the back turns each job into
// results. A job passes through the queue into the back's job register,
// where its first result becomes valid. A data byte in loading gives eight
// results, one per bit, set by the back's bit counter; others give one.
// When the receiver stalls, the current result holds and the queue fills;
// once it is full, i_in.ready drops until the back moves on.
// Synchronous reset returns the sequence to idle with attempt zero, loads
// the register defaults and empties the queue; no results are pending.
module fpga_passive_serial_loader
    import fpsl_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    fpsl_in_if.sink               i_in,
    fpsl_out_if.source            o_out
);

    // Front to queue, and queue to back.
    logic q_push;
    logic q_full;
    t_job q_wr_job;
    logic q_valid;
    logic q_pop;
    t_job q_rd_job;

    // The front classifies each command and advances the sequence state.
    fpsl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_job    (q_wr_job)
    );

    // The queue lets the front keep accepting ticks while a byte shifts out.
    fpsl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_wr_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_rd_job),
        .i_pop   (q_pop)
    );

    // The back emits the results, one transfer per cycle while the receiver is ready.
    fpsl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (q_rd_job),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    import fpsl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD_NS  = 10;
    localparam int RESET_CYCLES   = 8;
    // The receiver stall must be long enough to fill the job queue and push
    // back on the input, and the watchdog limit must sit well above it.
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int IDLE_PERCENT    = 12;

    // Codes that the package enums leave out: command 3 is ignored by the
    // block and register index 3 selects nothing.
    localparam logic [1:0]           CMD_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int N_PHASES       = 6;
    localparam int CALM_PHASE     = 3;
    localparam int PRESSURE_PHASE = 4;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fpsl_in_if  in_ch ();
    fpsl_out_if out_ch ();

    fpga_passive_serial_loader dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #(CLK_PERIOD_NS / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Loader model: our own copy of the configuration and sequence state.
    // It is advanced once per accepted input transfer and appends the
    // results that transfer must produce to the queue of pending results.
    // ------------------------------------------------------------------
    logic [7:0]  cfg_attempts;
    logic [15:0] cfg_timeout;
    logic [15:0] cfg_hold;

    t_status     seq_phase;
    logic [15:0] tick_cnt;
    logic [7:0]  attempt_cnt;
    bit          replay_req;

    t_out_item   pending_results[$];

    function automatic t_out_item make_result(logic nc, logic d0, logic pulse,
                                              t_status st, logic [7:0] att,
                                              logic fin);
        t_out_item r;
        r.nconfig_drive  = nc;
        r.data0_drive    = d0;
        r.dclk_pulse     = pulse;
        r.status         = st;
        r.attempt_number = att;
        r.last_of_run    = fin;
        return r;
    endfunction

    // nCONFIG is pulled low exactly while the sequence sits in reset hold,
    // which is also true for the retry result that re-enters the hold.
    function automatic void push_result(logic d0, logic pulse, t_status st, logic fin);
        pending_results.push_back(make_result(seq_phase != ST_HOLD, d0, pulse, st,
                                              attempt_cnt, fin));
    endfunction

    // A failed attempt either starts the next one at once, asking the
    // source to replay the bitstream, or gives up for good.
    function automatic void lose_attempt();
        tick_cnt = '0;
        if (attempt_cnt < cfg_attempts) begin
            attempt_cnt = attempt_cnt + 8'd1;
            seq_phase   = ST_HOLD;
            replay_req  = 1'b1;
        end else begin
            seq_phase = ST_FAILED;
        end
    endfunction

    // End of reset hold. nSTATUS is sampled right at release; a zero
    // timeout means the release sample is the only chance and it fails.
    function automatic void release_nconfig(logic nstat);
        if (cfg_timeout == 16'd0) begin
            lose_attempt();
        end else if (nstat) begin
            seq_phase = ST_LOAD;
            tick_cnt  = '0;
        end else begin
            seq_phase = ST_SYNC;
            tick_cnt  = 16'd1;
        end
    endfunction

    function automatic void predict_loader(t_in_item it);
        replay_req = 1'b0;
        if (it.command == CMD_DATA && seq_phase == ST_LOAD) begin
            // Seven pulses show the loading status; the eighth carries the
            // status after nSTATUS and the last-byte flag are looked at.
            for (int b = 0; b < BITS_PER_BYTE - 1; b++) begin
                push_result(it.data_byte[b], 1'b1, ST_LOAD, 1'b0);
            end
            if (!it.nstatus_pin) begin
                lose_attempt();
            end else if (it.last_byte) begin
                tick_cnt = '0;
                if (it.cdone_pin)
                    seq_phase = ST_OK;
                else if (cfg_timeout == 16'd0)
                    lose_attempt();
                else
                    seq_phase = ST_DONE;
            end
            push_result(it.data_byte[BITS_PER_BYTE-1], 1'b1,
                        replay_req ? ST_RETRY : seq_phase, 1'b1);
            return;
        end
        if (it.command == CMD_START) begin
            // A start restarts from attempt one whatever the phase, unless zero attempts are set.
            tick_cnt    = '0;
            attempt_cnt = '0;
            if (cfg_attempts == 8'd0) begin
                seq_phase = ST_FAILED;
            end else begin
                attempt_cnt = 8'd1;
                seq_phase   = ST_HOLD;
            end
        end else if (it.command == CMD_TICK) begin
            if (seq_phase == ST_HOLD) begin
                // The hold count saturates, and a hold of zero acts as one.
                if (tick_cnt != 16'hFFFF) tick_cnt = tick_cnt + 16'd1;
                if (tick_cnt >= cfg_hold) release_nconfig(it.nstatus_pin);
            end else if (seq_phase == ST_SYNC) begin
                if (tick_cnt >= cfg_timeout) begin
                    lose_attempt();
                end else if (it.nstatus_pin) begin
                    seq_phase = ST_LOAD;
                    tick_cnt  = '0;
                end else begin
                    tick_cnt = tick_cnt + 16'd1;
                end
            end else if (seq_phase == ST_DONE) begin
                if (tick_cnt != 16'hFFFF) tick_cnt = tick_cnt + 16'd1;
                if (it.cdone_pin) begin
                    seq_phase = ST_OK;
                    tick_cnt  = '0;
                end else if (tick_cnt >= cfg_timeout) begin
                    lose_attempt();
                end
            end
        end
        // Everything else (ticks in other phases, bytes outside loading,
        // the unused command) leaves the state alone and yields one result.
        push_result(1'b0, 1'b0, replay_req ? ST_RETRY : seq_phase, 1'b1);
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] val);
        if (idx == CFG_MAX_ATTEMPTS)
            cfg_attempts = val[7:0];
        else if (idx == CFG_SYNC_TIMEOUT)
            cfg_timeout = val;
        else if (idx == CFG_RESET_HOLD)
            cfg_hold = val;
    endfunction

    // ------------------------------------------------------------------
    // Result checking and the receiver side of the output channel.
    // ------------------------------------------------------------------
    int        fail_count = 0;
    int        stall_left = 0;
    bit        backpressure_done = 1'b0;
    bit        backpressure_req;
    bit        calm;
    t_out_item want;

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                note_failure($sformatf("result with nothing pending: status=%0d attempt=%0d",
                                       out_ch.data.status, out_ch.data.attempt_number));
            end else begin
                want = pending_results.pop_front();
                if (out_ch.data !== want) begin
                    note_failure($sformatf(
                        {"result mismatch: expected nconfig=%0b data0=%0b dclk=%0b ",
                         "status=%0d attempt=%0d last=%0b, got nconfig=%0b data0=%0b ",
                         "dclk=%0b status=%0d attempt=%0d last=%0b"},
                        want.nconfig_drive, want.data0_drive, want.dclk_pulse,
                        want.status, want.attempt_number, want.last_of_run,
                        out_ch.data.nconfig_drive, out_ch.data.data0_drive,
                        out_ch.data.dclk_pulse, out_ch.data.status,
                        out_ch.data.attempt_number, out_ch.data.last_of_run));
                end
            end
        end

        // Ready for the next cycle: a single long hold-off when asked for,
        // otherwise random stalls unless the calm stretch is running.
        if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if (backpressure_req && !backpressure_done) begin
            stall_left        <= HOLD_OFF_CYCLES - 1;
            backpressure_done <= 1'b1;
            out_ch.ready      <= 1'b0;
        end else begin
            out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too many cycles without any transfer on either channel
    // means the block has hung.
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender side and configuration writes.
    // ------------------------------------------------------------------

    // Offers one command and holds it until the transfer happens, then
    // lets the model work out what the block must return for it.
    task automatic send_item(t_in_item it);
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        predict_loader(it);
    endtask

    task automatic idle_gap();
        int gap;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PERCENT) gap++;
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stops offering and waits until every pending result has come back.
    // Each command produces at least one result, so once the queue is
    // empty the block is idle apart from a short pipeline tail.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        apply_register(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random commands steered by the model's phase, so most of them walk a
    // proper sequence: start, hold ticks, sync ticks, a handful of bytes
    // ending in a last byte, then done ticks. A small share is pure noise.
    function automatic t_in_item pick_item();
        t_in_item it;
        it.command     = CMD_TICK;
        it.data_byte   = 8'($urandom_range(255));
        it.last_byte   = 1'($urandom_range(1));
        it.nstatus_pin = 1'($urandom_range(1));
        it.cdone_pin   = 1'($urandom_range(1));
        if ($urandom_range(99) < 8) begin
            it.command = 2'($urandom_range(3));
            return it;
        end
        case (seq_phase)
            ST_HOLD: begin
                it.command = CMD_TICK;
            end
            ST_SYNC: begin
                it.command     = CMD_TICK;
                it.nstatus_pin = ($urandom_range(99) < 35);
            end
            ST_LOAD: begin
                it.command     = ($urandom_range(99) < 3) ? CMD_START : CMD_DATA;
                it.nstatus_pin = ($urandom_range(99) < 94);
                it.last_byte   = ($urandom_range(99) < 20);
            end
            ST_DONE: begin
                it.command   = CMD_TICK;
                it.cdone_pin = ($urandom_range(99) < 30);
            end
            default: begin
                it.command = ($urandom_range(99) < 70) ? CMD_START : CMD_TICK;
            end
        endcase
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Directed table. Rows either write a register (after draining) or
    // send a command. Single-result rows whose answer is obvious carry it
    // typed in; the rest are checked against the model.
    // ------------------------------------------------------------------
    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_val;
        t_in_item              item;
        bit                    typed;
        t_out_item             typed_result;
    } t_dir_row;

    function automatic t_dir_row row_cmd(logic [1:0] cmd, logic [7:0] byte_val,
                                         logic last, logic nstat, logic cdone);
        t_dir_row r;
        r.is_cfg           = 1'b0;
        r.cfg_idx          = '0;
        r.cfg_val          = '0;
        r.item.command     = cmd;
        r.item.data_byte   = byte_val;
        r.item.last_byte   = last;
        r.item.nstatus_pin = nstat;
        r.item.cdone_pin   = cdone;
        r.typed            = 1'b0;
        r.typed_result     = '0;
        return r;
    endfunction

    function automatic t_dir_row row_known(logic [1:0] cmd, logic [7:0] byte_val,
                                           logic last, logic nstat, logic cdone,
                                           logic nc, t_status st, logic [7:0] att);
        t_dir_row r;
        r              = row_cmd(cmd, byte_val, last, nstat, cdone);
        r.typed        = 1'b1;
        r.typed_result = make_result(nc, 1'b0, 1'b0, st, att, 1'b1);
        return r;
    endfunction

    function automatic t_dir_row row_cfg(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
        t_dir_row r;
        r         = row_cmd(CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0);
        r.is_cfg  = 1'b1;
        r.cfg_idx = idx;
        r.cfg_val = val;
        return r;
    endfunction

    t_dir_row directed_rows[$];

    // Settings for the random phases: the extremes in phases 1 and 2, a
    // zero timeout with retries in phase 5, ordinary small values elsewhere.
    logic [CFG_DATA_W-1:0] phase_attempts [N_PHASES] = '{3, 0, 255, 1, 4, 2};
    logic [CFG_DATA_W-1:0] phase_timeout  [N_PHASES] = '{3, 0, 16'hFFFF, 1, 5, 0};
    logic [CFG_DATA_W-1:0] phase_hold     [N_PHASES] = '{2, 0, 16'hFFFF, 1, 3, 2};
    int                    phase_items    [N_PHASES] = '{70, 40, 30, 70, 90, 60};

    initial begin
        // Every block input is known from time zero.
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        in_ch.valid      = 1'b0;
        in_ch.data       = '0;
        out_ch.ready     = 1'b0;
        calm             = 1'b0;
        backpressure_req = 1'b0;

        cfg_attempts = MAX_ATTEMPTS_RST;
        cfg_timeout  = SYNC_TIMEOUT_RST;
        cfg_hold     = RESET_HOLD_RST;
        seq_phase    = ST_IDLE;
        tick_cnt     = '0;
        attempt_cnt  = '0;
        replay_req   = 1'b0;

        // With the reset defaults: ignored commands in idle, then a start
        // and one hold tick that is far from the thousand-tick hold.
        directed_rows.push_back(row_known(CMD_TICK, 8'h00, 0, 0, 0, 1, ST_IDLE, 0));
        directed_rows.push_back(row_known(CMD_DATA, 8'hFF, 1, 1, 1, 1, ST_IDLE, 0));
        directed_rows.push_back(row_known(CMD_UNUSED, 8'hA5, 1, 1, 1, 1, ST_IDLE, 0));
        directed_rows.push_back(row_known(CMD_START, 8'h00, 0, 0, 0, 0, ST_HOLD, 1));
        directed_rows.push_back(row_known(CMD_TICK, 8'h00, 0, 0, 0, 0, ST_HOLD, 1));
        // Two attempts, a two-tick timeout and a zero hold, which acts as
        // a hold of one tick.
        directed_rows.push_back(row_cfg(CFG_MAX_ATTEMPTS, 16'd2));
        directed_rows.push_back(row_cfg(CFG_SYNC_TIMEOUT, 16'd2));
        directed_rows.push_back(row_cfg(CFG_RESET_HOLD, 16'd0));
        // Sync timeout leads to a retry, then a byte with nSTATUS low uses
        // up the last attempt.
        directed_rows.push_back(row_known(CMD_START, 8'h00, 0, 0, 0, 0, ST_HOLD, 1));
        directed_rows.push_back(row_cmd(CMD_TICK, 8'h00, 0, 0, 0));
        directed_rows.push_back(row_cmd(CMD_TICK, 8'h00, 0, 0, 0));
        directed_rows.push_back(row_known(CMD_TICK, 8'h00, 0, 0, 0, 0, ST_RETRY, 2));
        directed_rows.push_back(row_cmd(CMD_TICK, 8'h00, 0, 1, 0));
        directed_rows.push_back(row_cmd(CMD_DATA, 8'h00, 0, 1, 0));
        directed_rows.push_back(row_cmd(CMD_DATA, 8'hFF, 0, 1, 0));
        directed_rows.push_back(row_cmd(CMD_DATA, 8'hA5, 0, 0, 1));
        // Release straight into loading, and a last byte with the done
        // line already high.
        directed_rows.push_back(row_known(CMD_START, 8'h00, 0, 0, 0, 0, ST_HOLD, 1));
        directed_rows.push_back(row_cmd(CMD_TICK, 8'h00, 0, 1, 0));
        directed_rows.push_back(row_cmd(CMD_DATA, 8'h3C, 1, 1, 1));
        // A done-line timeout leads to a retry; the replay then succeeds on
        // a done tick.
        directed_rows.push_back(row_known(CMD_START, 8'h00, 0, 0, 0, 0, ST_HOLD, 1));
        directed_rows.push_back(row_cmd(CMD_TICK, 8'h00, 0, 1, 0));
        directed_rows.push_back(row_cmd(CMD_DATA, 8'h81, 1, 1, 0));
        directed_rows.push_back(row_cmd(CMD_TICK, 8'h00, 0, 1, 0));
        directed_rows.push_back(row_known(CMD_TICK, 8'h00, 0, 1, 0, 0, ST_RETRY, 2));
        directed_rows.push_back(row_cmd(CMD_TICK, 8'h00, 0, 1, 0));
        directed_rows.push_back(row_cmd(CMD_DATA, 8'h5A, 1, 1, 0));
        directed_rows.push_back(row_known(CMD_TICK, 8'h00, 0, 0, 1, 1, ST_OK, 2));
        // A start in the middle of loading restarts from attempt one.
        directed_rows.push_back(row_known(CMD_START, 8'h00, 0, 0, 0, 0, ST_HOLD, 1));
        directed_rows.push_back(row_cmd(CMD_TICK, 8'h00, 0, 1, 0));
        directed_rows.push_back(row_known(CMD_START, 8'hC3, 1, 1, 1, 0, ST_HOLD, 1));
        // The unused register index is ignored; zero attempts fails at once.
        directed_rows.push_back(row_cfg(CFG_UNUSED, 16'hFFFF));
        directed_rows.push_back(row_cfg(CFG_MAX_ATTEMPTS, 16'd0));
        directed_rows.push_back(row_known(CMD_START, 8'h00, 0, 1, 1, 1, ST_FAILED, 0));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_cfg) begin
                drain_results();
                write_reg(directed_rows[r].cfg_idx, directed_rows[r].cfg_val);
            end else begin
                send_item(directed_rows[r].item);
                if (directed_rows[r].typed)
                    pending_results[pending_results.size() - 1] =
                        directed_rows[r].typed_result;
                idle_gap();
            end
        end

        // Random phases, each under its own register setting. The calm
        // phase turns off idling on both sides; the pressure phase starts
        // with a long receiver hold-off while commands keep coming.
        for (int p = 0; p < N_PHASES; p++) begin
            drain_results();
            write_reg(CFG_MAX_ATTEMPTS, phase_attempts[p]);
            write_reg(CFG_SYNC_TIMEOUT, phase_timeout[p]);
            write_reg(CFG_RESET_HOLD, phase_hold[p]);
            calm             <= (p == CALM_PHASE);
            backpressure_req <= (p == PRESSURE_PHASE);
            @(posedge i_clk);
            for (int n = 0; n < phase_items[p]; n++) begin
                send_item(pick_item());
                idle_gap();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        fail_count += pending_results.size();

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
